>>> rtl/cetf_pkg.sv
package cetf_pkg;

    // kind of work the front hands to the back
    typedef enum logic [2:0] {
        OP_NONE     = 3'd0,
        OP_PASS     = 3'd1,
        OP_LETTER   = 3'd2,
        OP_OCTAL    = 3'd3,
        OP_ELLIPSIS = 3'd4
    } t_op;

    // one queue entry: what to emit and whether a terminator follows
    typedef struct packed {
        t_op        op;
        logic [7:0] data;
        logic       last;
    } t_entry;

    localparam logic [6:0] CH_NUL       = 7'h00;
    localparam logic [6:0] CH_SPACE     = 7'h20;
    localparam logic [6:0] CH_DOT       = 7'h2E;
    localparam logic [6:0] CH_ZERO      = 7'h30;
    localparam logic [6:0] CH_BACKSLASH = 7'h5C;

    localparam logic [7:0] PRINT_LO    = 8'h20;
    localparam logic [7:0] PRINT_HI    = 8'h7E;
    localparam logic [7:0] LIMIT_RESET = 8'd62;
    localparam logic [8:0] COUNT_MAX   = 9'd511;

    // escape letter of a control byte, zero when the byte has none
    function automatic logic [6:0] escape_letter(input logic [7:0] b);
        logic [6:0] l;
        case (b)
            8'h07:   l = 7'h61; // a
            8'h08:   l = 7'h62; // b
            8'h0C:   l = 7'h66; // f
            8'h0A:   l = 7'h6E; // n
            8'h0D:   l = 7'h72; // r
            8'h09:   l = 7'h74; // t
            8'h0B:   l = 7'h76; // v
            default: l = CH_NUL;
        endcase
        return l;
    endfunction

    // number of text characters an op produces
    function automatic logic [2:0] op_chars(input t_op op);
        logic [2:0] n;
        case (op)
            OP_PASS:     n = 3'd1;
            OP_LETTER:   n = 3'd2;
            OP_OCTAL:    n = 3'd4;
            OP_ELLIPSIS: n = 3'd4;
            default:     n = 3'd0;
        endcase
        return n;
    endfunction

endpackage

>>> rtl/cetf_in_if.sv
interface cetf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last_in;

    modport source (output valid, output in_byte, output last_in, input ready);
    modport sink   (input valid, input in_byte, input last_in, output ready);
endinterface

>>> rtl/cetf_out_if.sv
interface cetf_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] out_char;
    logic       last_out;

    modport source (output valid, output out_char, output last_out, input ready);
    modport sink   (input valid, input out_char, input last_out, output ready);
endinterface

>>> rtl/cetf_front.sv
module cetf_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [7:0]      i_cfg_data,
    cetf_in_if.sink         i_in,
    input  logic            i_q_full,
    output logic            o_push,
    output cetf_pkg::t_entry o_entry
);
    import cetf_pkg::*;

    logic [7:0] r_limit;
    logic [8:0] r_count, n_count;
    logic       r_cut, n_cut;
    logic       w_accept;
    logic [2:0] w_add;
    logic [9:0] w_sum;
    logic [6:0] w_letter;
    t_entry     w_entry;

    assign i_in.ready = !i_q_full;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_letter   = escape_letter(i_in.in_byte);
    assign w_sum      = {1'b0, r_count} + {7'd0, w_add};

    // classify the byte and advance the column count
    always_comb begin
        w_entry.op   = OP_NONE;
        w_entry.data = i_in.in_byte;
        w_entry.last = i_in.last_in;
        w_add        = 3'd0;
        n_cut        = r_cut;
        if (!r_cut) begin
            if (r_count >= {1'b0, r_limit}) begin
                w_entry.op = OP_ELLIPSIS;
                w_add      = 3'd4;
                n_cut      = 1'b1;
            end else if (i_in.in_byte >= PRINT_LO && i_in.in_byte <= PRINT_HI) begin
                w_entry.op = OP_PASS;
                w_add      = 3'd1;
            end else if (w_letter != CH_NUL) begin
                w_entry.op   = OP_LETTER;
                w_entry.data = {1'b0, w_letter};
                w_add        = 3'd2;
            end else begin
                w_entry.op = OP_OCTAL;
                w_add      = 3'd4;
            end
        end
        n_count = w_sum[9] ? COUNT_MAX : w_sum[8:0];
        // end of string starts the next one fresh
        if (i_in.last_in) begin
            n_count = '0;
            n_cut   = 1'b0;
        end
    end

    assign o_push  = w_accept && (w_entry.op != OP_NONE || w_entry.last);
    assign o_entry = w_entry;

    // limit register and string state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
            r_count <= '0;
            r_cut   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            if (w_accept) begin
                r_count <= n_count;
                r_cut   <= n_cut;
            end
        end
    end

    // count never exceeds the worst overshoot of a cut string
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 9'd262)
        else $error("column count beyond reachable range");

    // a cut string has always emitted the ellipsis
    a_cut_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cut |-> r_count >= 9'd4)
        else $error("cut flag set without ellipsis count");

endmodule

>>> rtl/cetf_queue.sv
module cetf_queue #(
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  cetf_pkg::t_entry i_entry,
    output logic             o_full,
    input  logic             i_pop,
    output cetf_pkg::t_entry o_head,
    output logic             o_empty
);
    import cetf_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr, r_rd;
    logic [CNT_W-1:0]   r_cnt;
    logic               w_push, w_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // no transfer is lost against a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

endmodule

>>> rtl/cetf_back.sv
module cetf_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  cetf_pkg::t_entry i_head,
    input  logic             i_empty,
    output logic             o_pop,
    cetf_out_if.source       o_out
);
    import cetf_pkg::*;

    logic       r_valid;
    logic [6:0] r_char;
    logic       r_last;
    logic [2:0] r_idx;
    logic [2:0] w_nchar, w_len;
    logic [6:0] w_char;
    logic       w_last, w_step, w_end;

    assign w_nchar = op_chars(i_head.op);
    assign w_len   = w_nchar + {2'd0, i_head.last};
    assign w_step  = !i_empty && (!r_valid || o_out.ready);
    assign w_end   = (r_idx == w_len - 3'd1);
    assign o_pop   = w_step && w_end;

    // character at the current position of the head entry
    always_comb begin
        w_char = CH_NUL;
        w_last = 1'b0;
        if (r_idx < w_nchar) begin
            case (i_head.op)
                OP_PASS: begin
                    w_char = i_head.data[6:0];
                end
                OP_LETTER: begin
                    w_char = (r_idx == 3'd0) ? CH_BACKSLASH : i_head.data[6:0];
                end
                OP_OCTAL: begin
                    case (r_idx)
                        3'd0:    w_char = CH_BACKSLASH;
                        3'd1:    w_char = CH_ZERO + {5'd0, i_head.data[7:6]};
                        3'd2:    w_char = CH_ZERO + {4'd0, i_head.data[5:3]};
                        default: w_char = CH_ZERO + {4'd0, i_head.data[2:0]};
                    endcase
                end
                OP_ELLIPSIS: begin
                    w_char = (r_idx == 3'd0) ? CH_SPACE : CH_DOT;
                end
                default: begin
                    w_char = CH_NUL;
                end
            endcase
        end else begin
            w_last = 1'b1;
        end
    end

    // output register and position counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (w_step) begin
                r_valid <= 1'b1;
                r_idx   <= w_end ? 3'd0 : r_idx + 3'd1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_char <= w_char;
            r_last <= w_last;
        end
    end

    assign o_out.valid    = r_valid;
    assign o_out.out_char = r_char;
    assign o_out.last_out = r_last;

    // terminator carries character zero
    a_term_nul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_last |-> r_char == CH_NUL)
        else $error("terminator with nonzero character");

    // position never runs past the longest sequence
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= 3'd4)
        else $error("sequence position out of range");

endmodule

>>> rtl/c_escape_text_formatter_top.sv
// C-style escape text formatter. Bytes come in one per transfer on i_in and
// leave as display text, one character per transfer on o_out: printable bytes
// as they are, the seven common control bytes as a backslash and a letter,
// everything else as a backslash and three octal digits. Once the column
// count reaches the limit written through i_cfg_we/i_cfg_data (reset 62), the
// string is cut with " ..." and its remaining bytes are dropped; the last
// byte of a string is always followed by a terminator (character 0, last_out
// high). The front accepts one byte per cycle while the entry queue of
// QUEUE_DEPTH entries has room; the back emits one character per cycle while
// o_out is ready, so a byte takes one character (printable), two (letter
// escape) or four (octal escape or ellipsis) of output, plus one for the
// terminator, and a dropped byte takes none. The output character port sets
// the sustained rate: five characters per byte at worst, for an octal escape or ellipsis on the last byte.
module c_escape_text_formatter_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    cetf_in_if.sink    i_in,
    cetf_out_if.source o_out
);
    import cetf_pkg::*;

    logic   w_push, w_full, w_pop, w_empty;
    t_entry w_entry, w_head;

    // classification and column state
    cetf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .i_q_full   (w_full),
        .o_push     (w_push),
        .o_entry    (w_entry)
    );

    // decoupling queue
    cetf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_empty (w_empty)
    );

    // character expansion
    cetf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule
